>>> hdl/clipped_sprite_blitter_rgb555_unit_assert.svh
// Assertion macros shared by the sprite blitter RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef CLIPPED_SPRITE_BLITTER_RGB555_UNIT_ASSERT_SVH
`define CLIPPED_SPRITE_BLITTER_RGB555_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is asserted.
`define CSB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("sprite blitter assertion failed");
// Clocked check that also holds during reset.
`define CSB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sprite blitter assertion failed");
`else
`define CSB_ASSERT(label, clk, rst_n, prop)
`define CSB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hdl/csb_pkg.sv
// Shared types and constants for the clipped RGB555 sprite blitter.
// No dependencies; used by csb_pixel_calc and the top level.
package csb_pkg;

  // Screen geometry.
  localparam int unsigned SCREEN_WIDTH  = 256;
  localparam int unsigned SCREEN_HEIGHT = 192;

  // Field widths.
  localparam int unsigned COORD_W = 11;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned POS_W   = COORD_W + 1;

  // Input tdata layout, lowest bit first.
  localparam int unsigned START_X_LSB = 0;
  localparam int unsigned START_Y_LSB = START_X_LSB + COORD_W;
  localparam int unsigned WIDTH_LSB   = START_Y_LSB + COORD_W;
  localparam int unsigned HEIGHT_LSB  = WIDTH_LSB + SIZE_W;
  localparam int unsigned BLEND_LSB   = HEIGHT_LSB + SIZE_W;
  localparam int unsigned SRC_LSB     = BLEND_LSB + 1;
  localparam int unsigned DST_LSB     = SRC_LSB + PIXEL_W;
  localparam int unsigned IN_USED_W   = DST_LSB + PIXEL_W;
  localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = ADDR_W + PIXEL_W;

  // Blend constants: drop the low bit of each channel, then set bit 15.
  localparam logic [PIXEL_W-1:0] KEEP_MASK  = 16'h7bde;
  localparam logic [PIXEL_W-1:0] BLEND_FLAG = 16'h8000;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef enum logic {
    MODE_OPAQUE = 1'b0,
    MODE_BLEND  = 1'b1
  } blend_e;

  // Current sprite and walk position.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    blend_e                    mode;
    logic [SIZE_W-1:0]         column;
    logic [SIZE_W-1:0]         row;
  } sprite_t;

  // Per-pixel outcome from the datapath.
  typedef struct packed {
    logic               active;
    logic               show;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] value;
    logic [SIZE_W-1:0]  next_column;
    logic [SIZE_W-1:0]  next_row;
  } pix_result_t;

endpackage

>>> hdl/csb_pixel_calc.sv
// Pixel datapath: position, clipping, colour key, half blend and walk step.
// Depends on csb_pkg.
module csb_pixel_calc (
  input  csb_pkg::sprite_t              sprite_i,
  input  logic [csb_pkg::PIXEL_W-1:0]   src_pixel_i,
  input  logic [csb_pkg::PIXEL_W-1:0]   dst_pixel_i,
  output csb_pkg::pix_result_t          result_o
);
  import csb_pkg::*;

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    in_x;
  logic                    in_y;
  logic [ADDR_W-1:0]       row_base;
  logic [PIXEL_W-1:0]      blend_value;
  logic [SIZE_W:0]         column_inc;

  // Screen position of this pixel.
  always_comb begin
    pos_x = POS_W'(sprite_i.origin_x) + $signed({1'b0, (POS_W-1)'(sprite_i.column)});
    pos_y = POS_W'(sprite_i.origin_y) + $signed({1'b0, (POS_W-1)'(sprite_i.row)});
    in_x  = !pos_x[POS_W-1] && (pos_x < $signed(POS_W'(SCREEN_WIDTH)));
    in_y  = !pos_y[POS_W-1] && (pos_y < $signed(POS_W'(SCREEN_HEIGHT)));
  end

  // Row-major framebuffer address.
  assign row_base = ADDR_W'($unsigned(pos_y)) * ADDR_W'(SCREEN_WIDTH);

  // Half sum per channel; the masked low bits keep channels from carrying over.
  assign blend_value = (((src_pixel_i & KEEP_MASK) >> 1) + ((dst_pixel_i & KEEP_MASK) >> 1))
                       | BLEND_FLAG;

  assign column_inc = {1'b0, sprite_i.column} + (SIZE_W + 1)'(1);

  // Result and next walk position.
  always_comb begin
    result_o.active = (sprite_i.width != '0) && (sprite_i.height != '0)
                      && (sprite_i.row < sprite_i.height);
    result_o.addr   = row_base + ADDR_W'($unsigned(pos_x));
    if (sprite_i.mode == MODE_BLEND) begin
      result_o.value = blend_value;
      result_o.show  = in_x && in_y;
    end else begin
      result_o.value = src_pixel_i;
      result_o.show  = in_x && in_y && (src_pixel_i != '0);
    end
    if (column_inc >= {1'b0, sprite_i.width}) begin
      result_o.next_column = '0;
      result_o.next_row    = sprite_i.row + SIZE_W'(1);
    end else begin
      result_o.next_column = column_inc[SIZE_W-1:0];
      result_o.next_row    = sprite_i.row;
    end
  end

endmodule

>>> hdl/clipped_sprite_blitter_rgb555_unit.sv
// Top level of the clipped RGB555 sprite blitter with stream ports.
// Depends on csb_pkg, csb_pixel_calc and the assertion macro header.
// Throughput: one beat per cycle; the input register, the pixel datapath
// and the output register form a two-stage pipeline that stalls only on tready.
// Reset clears the sprite state to an empty sprite and both valid flags;
// pixel beats before the first start beat give no output.
`include "clipped_sprite_blitter_rgb555_unit_assert.svh"

module clipped_sprite_blitter_rgb555_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x[10:0], start_y[21:11], width[29:22], height[37:30], blend[38],
  // src_pixel[54:39], dst_pixel[70:55], zero pad[71]
  input  logic [csb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fb_address[15:0], pixel_value[31:16]
  output logic [csb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import csb_pkg::*;

  logic                  s1_valid_q, s1_valid_d;
  kind_e                 s1_kind_q;
  logic [IN_DATA_W-1:0]  s1_data_q;
  sprite_t               sprite_q, sprite_d;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  proc_en;
  logic                  in_fire;
  pix_result_t           result;

  // Pipeline control: stage one advances when the output register is free.
  assign proc_en       = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || proc_en;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  csb_pixel_calc u_calc (
    .sprite_i    (sprite_q),
    .src_pixel_i (s1_data_q[SRC_LSB +: PIXEL_W]),
    .dst_pixel_i (s1_data_q[DST_LSB +: PIXEL_W]),
    .result_o    (result)
  );

  // Next state of the input stage, sprite state and output register.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = s_axis_tvalid;
    end

    sprite_d = sprite_q;
    if (proc_en) begin
      if (s1_kind_q == KIND_START) begin
        sprite_d.origin_x = $signed(s1_data_q[START_X_LSB +: COORD_W]);
        sprite_d.origin_y = $signed(s1_data_q[START_Y_LSB +: COORD_W]);
        sprite_d.width    = s1_data_q[WIDTH_LSB +: SIZE_W];
        sprite_d.height   = s1_data_q[HEIGHT_LSB +: SIZE_W];
        sprite_d.mode     = blend_e'(s1_data_q[BLEND_LSB]);
        sprite_d.column   = '0;
        sprite_d.row      = '0;
      end else if (result.active) begin
        sprite_d.column = result.next_column;
        sprite_d.row    = result.next_row;
      end
    end

    m_valid_d = m_valid_q;
    if (proc_en) begin
      m_valid_d = (s1_kind_q == KIND_PIXEL) && result.active && result.show;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      sprite_q   <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      sprite_q   <= sprite_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_e'(s_axis_tuser);
      s1_data_q <= s_axis_tdata;
    end
    if (proc_en) begin
      m_data_q <= {result.value, result.addr};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks on the walk state and the produced beats.
  `CSB_ASSERT(a_row_bound, clk_i, rst_ni, sprite_q.row <= sprite_q.height)
  `CSB_ASSERT(a_col_bound, clk_i, rst_ni, (sprite_q.column == '0) || (sprite_q.column < sprite_q.width))
  `CSB_ASSERT(a_addr_on_screen, clk_i, rst_ni, m_axis_tvalid |-> (32'(m_axis_tdata[ADDR_W-1:0]) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)))
  `CSB_ASSERT(a_value_nonzero, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:ADDR_W] != '0))
  `CSB_ASSERT_ALWAYS(a_stall_only_full, clk_i, !s_axis_tready |-> s1_valid_q)

endmodule
